[rtl/core/slfp_pkg.sv]
package slfp_pkg;

  localparam logic [7:0] SOF_MARK = 8'hAA;

  localparam logic [1:0] ST_RECV = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;
  localparam logic [1:0] ST_TOUT = 2'd3;

  typedef enum logic [2:0] {
    PH_SOF,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHK
  } slfp_phase_t;

  // one queued result job from the front to the back
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cmd;
    logic [7:0] len;
  } slfp_job_t;

  // payload store write port
  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } slfp_wr_t;

  // back status toward the front
  typedef struct packed {
    logic frame_end;
  } slfp_back_stat_t;

endpackage

[rtl/core/slfp_in_if.sv]
interface slfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_time;

  modport source (output valid, output rx_byte, output arrival_time, input ready);
  modport sink (input valid, input rx_byte, input arrival_time, output ready);
endinterface

[rtl/core/slfp_out_if.sv]
interface slfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] frame_cmd;
  logic [4:0] frame_len;
  logic [3:0] byte_index;
  logic [7:0] payload_byte;
  logic       last;

  modport source (
    output valid, output status, output frame_cmd, output frame_len,
    output byte_index, output payload_byte, output last, input ready
  );
  modport sink (
    input valid, input status, input frame_cmd, input frame_len,
    input byte_index, input payload_byte, input last, output ready
  );
endinterface

[rtl/core/slfp_fifo.sv]
module slfp_fifo
  import slfp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  slfp_job_t din,
  output logic      full,
  input  logic      pop,
  output slfp_job_t dout,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  slfp_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/core/slfp_front.sv]
module slfp_front
  import slfp_pkg::*;
#(
  parameter int PAYLOAD_MAX = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_data,
  slfp_in_if.sink         rx,
  input  logic            q_full,
  output logic            q_push,
  output slfp_job_t       q_din,
  output slfp_wr_t        wr,
  input  slfp_back_stat_t bstat
);

  localparam int LW = $clog2(PAYLOAD_MAX + 1);

  slfp_phase_t phase;
  slfp_phase_t phase_next;
  slfp_phase_t eff_phase;
  logic [31:0] timeout_limit;
  logic [31:0] previous_time;
  logic [7:0]  command_reg;
  logic [LW-1:0] length_reg;
  logic [LW-1:0] received_count;
  logic [LW-1:0] count_inc;
  logic [7:0]  running_xor;
  logic        hold;
  logic        accept;
  logic        tout;
  logic        bad_len;
  logic [31:0] gap;
  logic [1:0]  hstat;
  logic [7:0]  b;

  assign b         = rx.rx_byte;
  assign rx.ready  = !q_full && !hold;
  assign accept    = rx.valid && rx.ready;
  assign gap       = rx.arrival_time - previous_time;
  assign tout      = (timeout_limit != '0) && (phase != PH_SOF) && (gap > timeout_limit);
  assign eff_phase = tout ? PH_SOF : phase;
  assign bad_len   = (32'(b) > PAYLOAD_MAX);
  assign count_inc = received_count + LW'(1);

  // next state
  always_comb begin
    phase_next = eff_phase;
    unique case (eff_phase)
      PH_SOF:  phase_next = (b == SOF_MARK) ? PH_CMD : PH_SOF;
      PH_CMD:  phase_next = PH_LEN;
      PH_LEN: begin
        if (bad_len) begin
          phase_next = PH_SOF;
        end else if (b == 8'd0) begin
          phase_next = PH_CHK;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: phase_next = (count_inc >= length_reg) ? PH_CHK : PH_DATA;
      PH_CHK:  phase_next = PH_SOF;
      default: phase_next = PH_SOF;
    endcase
  end

  // outputs
  always_comb begin
    hstat = ST_RECV;
    wr    = '0;
    unique case (eff_phase)
      PH_SOF:  hstat = ST_RECV;
      PH_CMD:  hstat = ST_RECV;
      PH_LEN:  hstat = bad_len ? ST_ERR : ST_RECV;
      PH_DATA: begin
        hstat   = ST_RECV;
        wr.we   = accept;
        wr.addr = 8'(received_count);
        wr.data = b;
      end
      PH_CHK:  hstat = (b == running_xor) ? ST_DONE : ST_ERR;
      default: hstat = ST_RECV;
    endcase
    q_push        = accept;
    q_din.status  = tout ? ST_TOUT : hstat;
    q_din.cmd     = (!tout && hstat == ST_DONE) ? command_reg : 8'd0;
    q_din.len     = (!tout && hstat == ST_DONE) ? 8'(length_reg) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= '0;
    end else if (cfg_we) begin
      timeout_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SOF;
      previous_time  <= '0;
      command_reg    <= '0;
      length_reg     <= '0;
      received_count <= '0;
      running_xor    <= '0;
      hold           <= 1'b0;
    end else begin
      if (bstat.frame_end) begin
        hold <= 1'b0;
      end
      if (accept) begin
        phase <= phase_next;
        if (hstat == ST_RECV) begin
          previous_time <= rx.arrival_time;
        end
        unique case (eff_phase)
          PH_SOF: begin
            running_xor    <= '0;
            received_count <= '0;
          end
          PH_CMD: begin
            command_reg <= b;
            running_xor <= running_xor ^ b;
          end
          PH_LEN: begin
            if (!bad_len) begin
              length_reg  <= LW'(b);
              running_xor <= running_xor ^ b;
            end
          end
          PH_DATA: begin
            received_count <= count_inc;
            running_xor    <= running_xor ^ b;
          end
          PH_CHK: begin
            // frame finished either way
            if (hstat == ST_DONE && length_reg != '0) begin
              hold <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/core/slfp_back.sv]
module slfp_back
  import slfp_pkg::*;
#(
  parameter int PAYLOAD_MAX = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  slfp_wr_t        wr,
  input  logic            q_empty,
  input  slfp_job_t       q_dout,
  output logic            q_pop,
  output slfp_back_stat_t bstat,
  slfp_out_if.source      result
);

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  logic [7:0] store [PAYLOAD_MAX];
  logic [7:0] mem_q;
  logic       o_valid;
  logic [1:0] o_status;
  logic [7:0] o_cmd;
  logic [7:0] o_len;
  logic [7:0] o_idx;
  logic       o_has;
  logic       o_last;
  logic       active;
  logic [7:0] cnt;
  logic [7:0] f_cmd;
  logic [7:0] f_len;
  logic       load;
  logic       last_now;
  logic       job_frame;

  assign load      = !o_valid || result.ready;
  assign q_pop     = !active && !q_empty && load;
  assign last_now  = (cnt + 8'd1 == f_len);
  assign job_frame = (q_dout.status == ST_DONE) && (q_dout.len != 8'd0);

  // all reads of the frame are done once its final entry is loaded
  assign bstat.frame_end = active && load && last_now;

  assign result.valid        = o_valid;
  assign result.status       = o_status;
  assign result.frame_cmd    = o_cmd;
  assign result.frame_len    = o_len[4:0];
  assign result.byte_index   = o_idx[3:0];
  assign result.payload_byte = o_has ? mem_q : 8'd0;
  assign result.last         = o_last;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      store[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      active  <= 1'b0;
      cnt     <= '0;
    end else begin
      if (active && load) begin
        o_valid <= 1'b1;
        cnt     <= cnt + 8'd1;
        if (last_now) begin
          active <= 1'b0;
        end
      end else if (q_pop) begin
        cnt <= '0;
        if (job_frame) begin
          active  <= 1'b1;
          o_valid <= 1'b0;
        end else begin
          o_valid <= 1'b1;
        end
      end else if (load) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && load) begin
      o_status <= ST_DONE;
      o_cmd    <= f_cmd;
      o_len    <= f_len;
      o_idx    <= cnt;
      o_has    <= 1'b1;
      o_last   <= last_now;
      mem_q    <= store[cnt[AW-1:0]];
    end else if (q_pop) begin
      f_cmd    <= q_dout.cmd;
      f_len    <= q_dout.len;
      o_status <= q_dout.status;
      o_cmd    <= q_dout.cmd;
      o_len    <= q_dout.len;
      o_idx    <= '0;
      o_has    <= 1'b0;
      o_last   <= 1'b1;
    end
  end

endmodule

[rtl/core/sof_len_xor_frame_parser.sv]
// Serial frame parser: each input transaction is one received byte with its millisecond
// arrival time; frames are 0xAA, command, length (0 to PAYLOAD_MAX), payload and an XOR
// checksum over command, length and payload. One byte is taken per cycle unless held off,
// and each byte gives one result, except that a good frame's checksum byte gives one per
// payload byte (one result when the length is zero). While a completed frame with payload
// is emitted the input is held off until the output side, walking the payload store's
// single read port one entry a cycle when not stalled, has loaded the frame's last entry.
// A two-entry queue separates byte parsing from result output, so the input keeps running
// while a result waits at the output, until it is full. The user must write timeout_limit
// via cfg_we/cfg_data only while idle (unchecked); zero disables the inter-byte timeout.
module sof_len_xor_frame_parser
  import slfp_pkg::*;
#(
  parameter int PAYLOAD_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  slfp_in_if.sink     rx,
  slfp_out_if.source  result
);

  slfp_job_t       q_din;
  slfp_job_t       q_dout;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  slfp_wr_t        wr;
  slfp_back_stat_t bstat;

  slfp_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rx       (rx),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din),
    .wr       (wr),
    .bstat    (bstat)
  );

  slfp_fifo #(.DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  slfp_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .q_empty (q_empty),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .bstat   (bstat),
    .result  (result)
  );

endmodule

[rtl/core/slfp_checker.sv]
module slfp_checker
  import slfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_status,
  input logic [7:0] res_cmd,
  input logic [4:0] res_len,
  input logic [3:0] res_idx,
  input logic [7:0] res_data,
  input logic       res_last
);

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_data)
      && $stable(res_idx) && $stable(res_last))
    else $error("stalled result changed");

  // non-DONE results carry nothing
  a_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_DONE |->
      res_last && res_cmd == 8'd0 && res_len == 5'd0 && res_idx == 4'd0 && res_data == 8'd0)
    else $error("non-frame result with payload fields");

  // last marks the final payload byte
  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_DONE && res_len != 5'd0 |->
      ({1'b0, res_idx} < res_len) && (res_last == ({1'b0, res_idx} + 5'd1 == res_len)))
    else $error("bad byte index or last flag");

  // output is empty right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid after reset");

endmodule

bind sof_len_xor_frame_parser slfp_checker u_slfp_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_cmd    (result.frame_cmd),
  .res_len    (result.frame_len),
  .res_idx    (result.byte_index),
  .res_data   (result.payload_byte),
  .res_last   (result.last)
);
